>>> sv/rpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary position embedding package
// Shared widths, fixed-point constants and the item types on the ports and
// between the front and back parts of the block.
// ----------------------------------------------------------------------------
package rpe_pkg;

  localparam int POS_W       = 16;
  localparam int PAIR_W      = 6;
  localparam int VAL_W       = 16;
  localparam int RATE_W      = 32;
  localparam int TABLE_DEPTH = 64;
  localparam int ANGLE_W     = 30;
  localparam int QUAD_W      = 2;
  localparam int MID_DEPTH   = 4;
  localparam int OUT_DEPTH   = 2;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  typedef struct packed {
    logic [POS_W-1:0]        position;
    logic [PAIR_W-1:0]       pair_index;
    logic signed [VAL_W-1:0] first_value;
    logic signed [VAL_W-1:0] second_value;
    logic                    end_of_block;
  } rpe_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] rotated_first;
    logic signed [VAL_W-1:0] rotated_second;
    logic                    end_of_block_out;
  } rpe_out_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] first_value;
    logic signed [VAL_W-1:0] second_value;
    logic                    end_of_block;
    logic [QUAD_W-1:0]       quad;
    logic                    swap;
    logic [ANGLE_W-1:0]      angle;
  } rpe_work_t;

endpackage

>>> sv/rpe_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary position embedding queue
// Small first-in first-out queue of register entries with push/full and
// pop/empty sides; the head entry is visible while empty is low.
// ----------------------------------------------------------------------------
module rpe_fifo #(
  parameter int DEPTH = 4,
  parameter type item_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t wdata_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t rdata_o,
  output logic  empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  item_t            mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("Item pushed into a full queue.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && empty_o))
    else $error("Item popped from an empty queue.");
`endif

endmodule

>>> sv/rpe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary position embedding front
// Accepts items, looks up the turn rate of the pair, forms the phase and
// folds it into a quadrant, a swap flag and an octant angle.
// ----------------------------------------------------------------------------
module rpe_front #(
  parameter int HEAD_SIZE     = 128,
  parameter int BASE          = 10000,
  parameter int POSITION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               accept_i,
  input  rpe_pkg::rpe_in_t   item_i,
  output rpe_pkg::rpe_work_t work_o,
  output logic               work_valid_o
);
  import rpe_pkg::*;

  typedef logic [TABLE_DEPTH-1:0][RATE_W-1:0] rate_tab_t;

  localparam logic [63:0] TURN_GAIN = 64'd683565276;
  localparam int PosUsed = (POSITION_BITS < POS_W) ? POSITION_BITS : POS_W;
  localparam logic [POS_W-1:0] PosMask = POS_W'((33'd1 << PosUsed) - 33'd1);

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] rem_v;
    logic [63:0] res_v;
    logic [63:0] bit_v;
    rem_v = v;
    res_v = '0;
    bit_v = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem_v >= res_v + bit_v) begin
        rem_v = rem_v - (res_v + bit_v);
        res_v = (res_v >> 1) + bit_v;
      end else begin
        res_v = res_v >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res_v;
  endfunction

  function automatic rate_tab_t build_rate_table();
    logic [63:0] roots [31];
    logic [63:0] b, n, m, frac, lg, e, ei, ef, p, f;
    rate_tab_t   tab;
    b = (BASE < 1) ? 64'd1 : 64'(BASE);
    roots[0] = 64'(ONE_Q30) >> 1;
    for (int k = 1; k <= 30; k++) begin
      roots[k] = isqrt(roots[k-1] << 30);
    end
    n = '0;
    for (int i = 0; i < 63; i++) begin
      if ((b >> (n + 64'd1)) != 64'd0) begin
        n = n + 64'd1;
      end
    end
    m = (n <= 64'd30) ? (b << (64'd30 - n)) : (b >> (n - 64'd30));
    frac = '0;
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'(ONE_Q30) << 1)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    lg = (n << 30) | frac;
    for (int d = 0; d < TABLE_DEPTH; d++) begin
      e  = (64'd2 * 64'(d) * lg) / 64'(HEAD_SIZE);
      ei = e >> 30;
      ef = e & (64'(ONE_Q30) - 64'd1);
      p  = 64'(ONE_Q30);
      for (int k = 1; k <= 30; k++) begin
        if (((ef >> (30 - k)) & 64'd1) != 64'd0) begin
          p = (p * roots[k]) >> 30;
        end
      end
      f = (ei >= 64'd31) ? 64'd0 : (p >> ei);
      tab[d] = RATE_W'((f * TURN_GAIN) >> 30);
    end
    return tab;
  endfunction

  localparam rate_tab_t RATE_TABLE = build_rate_table();

  logic                    vld1_q, vld2_q;
  logic [POS_W-1:0]        pos1_q;
  logic [RATE_W-1:0]       rate1_q;
  logic signed [VAL_W-1:0] x1_q, y1_q, x2_q, y2_q;
  logic                    eob1_q, eob2_q;
  logic [RATE_W-1:0]       phase2_q;
  logic [POS_W+RATE_W-1:0] phase_full;

  assign phase_full = {{RATE_W{1'b0}}, pos1_q} * {{POS_W{1'b0}}, rate1_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= accept_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos1_q   <= item_i.position & PosMask;
      rate1_q  <= RATE_TABLE[item_i.pair_index];
      x1_q     <= item_i.first_value;
      y1_q     <= item_i.second_value;
      eob1_q   <= item_i.end_of_block;
      phase2_q <= phase_full[RATE_W-1:0];
      x2_q     <= x1_q;
      y2_q     <= y1_q;
      eob2_q   <= eob1_q;
    end
  end

  always_comb begin
    work_o.first_value  = x2_q;
    work_o.second_value = y2_q;
    work_o.end_of_block = eob2_q;
    work_o.quad         = phase2_q[RATE_W-1:RATE_W-QUAD_W];
    work_o.swap         = phase2_q[ANGLE_W-1];
    if (phase2_q[ANGLE_W-1]) begin
      work_o.angle = ANGLE_W'(ONE_Q30 - {1'b0, phase2_q[ANGLE_W-1:0]});
    end else begin
      work_o.angle = phase2_q[ANGLE_W-1:0];
    end
  end

  assign work_valid_o = vld2_q;

endmodule

>>> sv/rpe_divc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary position embedding constant divider
// Two-stage floor division of a Q30 value by a fixed divisor: a reciprocal
// multiply followed by a single remainder correction.
// ----------------------------------------------------------------------------
module rpe_divc #(
  parameter int DIVISOR = 6
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [rpe_pkg::ANGLE_W-1:0] x_i,
  output logic [rpe_pkg::ANGLE_W-1:0] q_o
);
  import rpe_pkg::*;

  localparam logic [31:0] Recip = 32'(64'h1_0000_0000 / 64'(DIVISOR));

  logic [ANGLE_W+31:0] prod_q;
  logic [ANGLE_W-1:0]  x_q, q_q;
  logic [ANGLE_W-1:0]  q0;
  logic [ANGLE_W:0]    rem;

  assign q0  = prod_q[ANGLE_W+31:32];
  assign rem = {1'b0, x_q} - ({1'b0, q0} * (ANGLE_W + 1)'(DIVISOR));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= {32'd0, x_i} * {{ANGLE_W{1'b0}}, Recip};
      x_q    <= x_i;
      q_q    <= (rem >= (ANGLE_W + 1)'(DIVISOR)) ? q0 + 1'b1 : q0;
    end
  end

  assign q_o = q_q;

endmodule

>>> sv/rpe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary position embedding back
// Pipelined octant sine and cosine series, quadrant unfolding, rotation of
// the pair and rounding with saturation to Q3.12.
// ----------------------------------------------------------------------------
module rpe_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rpe_pkg::rpe_work_t work_i,
  input  logic               work_valid_i,
  output logic               work_pop_o,
  output rpe_pkg::rpe_out_t  result_o,
  output logic               result_push_o,
  input  logic               result_full_i
);
  import rpe_pkg::*;

  localparam int NLEV = 14;
  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic [QUAD_W-1:0] QUAD_I   = 2'd0;
  localparam logic [QUAD_W-1:0] QUAD_II  = 2'd1;
  localparam logic [QUAD_W-1:0] QUAD_III = 2'd2;
  localparam logic [QUAD_W-1:0] QUAD_IV  = 2'd3;

  typedef struct packed {
    logic signed [VAL_W-1:0] first_value;
    logic signed [VAL_W-1:0] second_value;
    logic                    end_of_block;
    logic [QUAD_W-1:0]       quad;
    logic                    swap;
  } side_t;

  function automatic logic signed [VAL_W-1:0] round_sat(input logic signed [32:0] v);
    logic signed [32:0]      t;
    logic signed [32:0]      r;
    logic signed [VAL_W-1:0] o;
    t = v + 33'sd8192;
    r = t >>> 14;
    if (r > 33'sd32767) begin
      o = 16'sh7FFF;
    end else if (r < -33'sd32768) begin
      o = 16'sh8000;
    end else begin
      o = r[VAL_W-1:0];
    end
    return o;
  endfunction

  logic                adv;
  logic [NLEV:1]       vld_q;
  side_t               side_q [1:NLEV];
  logic [ANGLE_W-1:0]  t2_q [3:10];
  logic [ANGLE_W-1:0]  th_q [2:10];

  logic [62:0]         mth_q;
  logic [59:0]         mt2_q;
  logic [ANGLE_W-1:0]  th_w, t2_w;

  logic [ANGLE_W-1:0]  qs1, qs2, qs3, qc1, qc2, qc3;
  logic [ANGLE_W:0]    hs1, hs2, hs3, hc1, hc2, hc3;
  logic [60:0]         ps1_q, ps2_q, ps3_q, pc1_q, pc2_q, pc3_q;
  logic [ANGLE_W:0]    sin_w, cos_w, sel_s, sel_c;
  logic [31:0]         rnd_s, rnd_c;
  logic signed [VAL_W-1:0] mag_s, mag_c, sn_d, cs_d, sn_q, cs_q;
  logic signed [31:0]  pxc_q, pys_q, pxs_q, pyc_q;
  logic signed [VAL_W-1:0] rot1_q, rot2_q;

  assign adv           = !result_full_i;
  assign work_pop_o    = adv && work_valid_i;
  assign result_push_o = adv && vld_q[NLEV];

  assign th_w = mth_q[61:32];
  assign t2_w = mt2_q[59:30];

  rpe_divc #(.DIVISOR(42)) u_div_s1 (.clk_i, .en_i(adv), .x_i(t2_w),          .q_o(qs1));
  rpe_divc #(.DIVISOR(20)) u_div_s2 (.clk_i, .en_i(adv), .x_i(ps1_q[59:30]), .q_o(qs2));
  rpe_divc #(.DIVISOR(6))  u_div_s3 (.clk_i, .en_i(adv), .x_i(ps2_q[59:30]), .q_o(qs3));
  rpe_divc #(.DIVISOR(56)) u_div_c1 (.clk_i, .en_i(adv), .x_i(t2_w),          .q_o(qc1));
  rpe_divc #(.DIVISOR(30)) u_div_c2 (.clk_i, .en_i(adv), .x_i(pc1_q[59:30]), .q_o(qc2));
  rpe_divc #(.DIVISOR(12)) u_div_c3 (.clk_i, .en_i(adv), .x_i(pc2_q[59:30]), .q_o(qc3));

  assign hs1 = ONE_Q30 - {1'b0, qs1};
  assign hs2 = ONE_Q30 - {1'b0, qs2};
  assign hs3 = ONE_Q30 - {1'b0, qs3};
  assign hc1 = ONE_Q30 - {1'b0, qc1};
  assign hc2 = ONE_Q30 - {1'b0, qc2};
  assign hc3 = ONE_Q30 - {1'b0, qc3};

  assign sin_w = {1'b0, ps3_q[59:30]};
  assign cos_w = ONE_Q30 - {2'b00, pc3_q[59:31]};

  always_comb begin
    sel_s = side_q[11].swap ? cos_w : sin_w;
    sel_c = side_q[11].swap ? sin_w : cos_w;
    rnd_s = {1'b0, sel_s} + 32'h0000_8000;
    rnd_c = {1'b0, sel_c} + 32'h0000_8000;
    mag_s = {1'b0, rnd_s[30:16]};
    mag_c = {1'b0, rnd_c[30:16]};
    case (side_q[11].quad)
      QUAD_I: begin
        sn_d = mag_s;
        cs_d = mag_c;
      end
      QUAD_II: begin
        sn_d = mag_c;
        cs_d = -mag_s;
      end
      QUAD_III: begin
        sn_d = -mag_s;
        cs_d = -mag_c;
      end
      QUAD_IV: begin
        sn_d = -mag_c;
        cs_d = mag_s;
      end
      default: begin
        sn_d = '0;
        cs_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NLEV-1:1], work_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[1].first_value  <= work_i.first_value;
      side_q[1].second_value <= work_i.second_value;
      side_q[1].end_of_block <= work_i.end_of_block;
      side_q[1].quad         <= work_i.quad;
      side_q[1].swap         <= work_i.swap;
      for (int k = 2; k <= NLEV; k++) begin
        side_q[k] <= side_q[k-1];
      end

      mth_q   <= {33'd0, work_i.angle} * {30'd0, TWO_PI_Q30};
      mt2_q   <= {30'd0, th_w} * {30'd0, th_w};
      th_q[2] <= th_w;
      for (int k = 3; k <= 10; k++) begin
        th_q[k] <= th_q[k-1];
      end
      t2_q[3] <= t2_w;
      for (int k = 4; k <= 10; k++) begin
        t2_q[k] <= t2_q[k-1];
      end

      ps1_q <= {31'd0, t2_q[4]} * {30'd0, hs1};
      ps2_q <= {31'd0, t2_q[7]} * {30'd0, hs2};
      ps3_q <= {31'd0, th_q[10]} * {30'd0, hs3};
      pc1_q <= {31'd0, t2_q[4]} * {30'd0, hc1};
      pc2_q <= {31'd0, t2_q[7]} * {30'd0, hc2};
      pc3_q <= {31'd0, t2_q[10]} * {30'd0, hc3};

      sn_q <= sn_d;
      cs_q <= cs_d;

      pxc_q <= 32'(side_q[12].first_value) * 32'(cs_q);
      pys_q <= 32'(side_q[12].second_value) * 32'(sn_q);
      pxs_q <= 32'(side_q[12].first_value) * 32'(sn_q);
      pyc_q <= 32'(side_q[12].second_value) * 32'(cs_q);

      rot1_q <= round_sat(33'(pxc_q) - 33'(pys_q));
      rot2_q <= round_sat(33'(pxs_q) + 33'(pyc_q));
    end
  end

  assign result_o.rotated_first    = rot1_q;
  assign result_o.rotated_second   = rot2_q;
  assign result_o.end_of_block_out = side_q[NLEV].end_of_block;

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NLEV] && !adv) |=> vld_q[NLEV])
    else $error("Finished item lost while the result queue was full.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NLEV] && !adv) |=> ($stable(rot1_q) && $stable(rot2_q)))
    else $error("Finished item changed while the result queue was full.");
`endif

endmodule

>>> sv/rotary_position_embedding.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary position embedding
// Rotates one element pair per item by its position-dependent angle, with
// queue-style push/full input and pop/empty output.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while full is low and gives one
// result per item in order. An accepted item passes through two front
// stages that look up the turn rate and form the phase and fourteen back
// stages that evaluate the sine and cosine series with pipelined constant
// dividers, rotate the pair and saturate. The turn rate table is a constant
// built at elaboration from BASE and HEAD_SIZE. A four-entry queue sits
// between front and back and a two-entry queue holds finished results, so
// full rises only when results are not being taken.
// ----------------------------------------------------------------------------
module rotary_position_embedding #(
  parameter int HEAD_SIZE     = 128,
  parameter int BASE          = 10000,
  parameter int POSITION_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  rpe_pkg::rpe_in_t  item_i,
  input  logic              pop,
  output logic              empty,
  output rpe_pkg::rpe_out_t result_o
);
  import rpe_pkg::*;

  logic      accept;
  logic      front_en;
  rpe_work_t front_work;
  logic      front_valid;
  logic      mid_push, mid_full, mid_pop, mid_empty;
  rpe_work_t mid_work;
  rpe_out_t  back_result;
  logic      out_push, out_full, out_pop;

  assign accept   = push && !full;
  assign front_en = !mid_full;
  assign mid_push = front_en && front_valid;
  assign out_pop  = pop && !empty;
  assign full     = mid_full;

  rpe_front #(
    .HEAD_SIZE    (HEAD_SIZE),
    .BASE         (BASE),
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .en_i        (front_en),
    .accept_i    (accept),
    .item_i,
    .work_o      (front_work),
    .work_valid_o(front_valid)
  );

  rpe_fifo #(
    .DEPTH (MID_DEPTH),
    .item_t(rpe_work_t)
  ) u_mid_fifo (
    .clk_i,
    .rst_ni,
    .push_i (mid_push),
    .wdata_i(front_work),
    .full_o (mid_full),
    .pop_i  (mid_pop),
    .rdata_o(mid_work),
    .empty_o(mid_empty)
  );

  rpe_back u_back (
    .clk_i,
    .rst_ni,
    .work_i       (mid_work),
    .work_valid_i (!mid_empty),
    .work_pop_o   (mid_pop),
    .result_o     (back_result),
    .result_push_o(out_push),
    .result_full_i(out_full)
  );

  rpe_fifo #(
    .DEPTH (OUT_DEPTH),
    .item_t(rpe_out_t)
  ) u_out_fifo (
    .clk_i,
    .rst_ni,
    .push_i (out_push),
    .wdata_i(back_result),
    .full_o (out_full),
    .pop_i  (out_pop),
    .rdata_o(result_o),
    .empty_o(empty)
  );

endmodule
